// ===== src/obbsat_pkg.sv =====
// Shared constants for the oriented-box collision pipeline.
// Holds CORDIC angle table, CORDIC seed and output depth limits; no dependencies.
package obbsat_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int CORDIC_XW    = 34;
	localparam int CORDIC_ZW    = 33;
	localparam int DEPTH_W      = 20;

	localparam logic signed [CORDIC_XW-1:0] CORDIC_X0 = 34'sd652032874;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = 20'hFFFFF;

	localparam logic signed [CORDIC_ZW-1:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
		33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
		33'sd42667331, 33'sd21354465, 33'sd10679838, 33'sd5340245,
		33'sd2670163, 33'sd1335087, 33'sd667544, 33'sd333772,
		33'sd166886, 33'sd83443, 33'sd41721, 33'sd20861,
		33'sd10430, 33'sd5215, 33'sd2608, 33'sd1304,
		33'sd652, 33'sd326, 33'sd163, 33'sd81
	};

endpackage

// ===== src/obb_sat_collision_mtv_unit.sv =====
// Oriented-box separating-axis collision test with minimum translation vector.
// Depends on obbsat_pkg for the CORDIC table and depth limits.
//
//  channel | dir | handshake              | tdata fields (lowest bit first)
//  s_*     | in  | s_tvalid / s_tready    | box A cx,cy,angle,hw,hh then box B same
//  m_*     | out | m_tvalid / m_tready    | collides, mtv_x, mtv_y, mtv_depth
//
// One box pair enters per cycle while the output is not stalled; its result beat
// passes through 34 register stages: input, 24 CORDIC, 8 geometry, output.
// Reset clears only the valid bits; no other state is kept between pairs.
// A stalled output beat holds every stage; nothing is dropped or repeated.
module obb_sat_collision_mtv_unit #(
	parameter int COORD_WIDTH    = 16,
	parameter int ANGLE_WIDTH    = 16,
	parameter int UNIT_FRAC_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// a_center_x, a_center_y, a_angle, a_half_width, a_half_height, then b_* same
	input  logic [((2*(4*COORD_WIDTH-2+ANGLE_WIDTH)+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// collides, mtv_x, mtv_y, mtv_depth
	output logic [((1+2*(UNIT_FRAC_BITS+2)+obbsat_pkg::DEPTH_W+7)/8)*8-1:0] m_tdata
);

	localparam int CW    = COORD_WIDTH;
	localparam int AW    = ANGLE_WIDTH;
	localparam int UFB   = UNIT_FRAC_BITS;
	localparam int UW    = UFB + 2;
	localparam int BW    = 4*CW - 2 + AW;
	localparam int DW    = obbsat_pkg::DEPTH_W;
	localparam int OW    = 1 + 2*UW + DW;
	localparam int ODW   = ((OW+7)/8)*8;
	localparam int PRW   = UW + CW;
	localparam int VW    = CW + 4;
	localparam int PW    = UW + VW + 1;
	localparam int LW    = PW + 1;
	localparam int DCW   = CW + 1;
	localparam int DTW   = DCW + UW + 1;
	localparam int NS    = obbsat_pkg::CORDIC_STEPS;
	localparam int XW    = obbsat_pkg::CORDIC_XW;
	localparam int ZW    = obbsat_pkg::CORDIC_ZW;

	typedef struct packed {
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic [CW-2:0]        hw;
		logic [CW-2:0]        hh;
		logic [1:0]           q;
	} geo_t;

	logic en;
	logic out_vld_q;

	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = out_vld_q;

	// input decode and angle fold
	geo_t                  geo_in [2];
	logic signed [ZW-1:0]  z_in   [2];

	always_comb begin
		logic [BW-1:0]  f;
		logic [AW-1:0]  ang;
		logic [31:0]    t;
		logic [31:0]    ts;
		logic [31:0]    rr;
		for (int b = 0; b < 2; b++) begin
			f   = s_tdata[b*BW +: BW];
			ang = f[2*CW +: AW];
			geo_in[b].cx = f[0 +: CW];
			geo_in[b].cy = f[CW +: CW];
			geo_in[b].hw = f[2*CW+AW +: CW-1];
			geo_in[b].hh = f[3*CW+AW-1 +: CW-1];
			t  = {ang, {(32-AW){1'b0}}};
			ts = t + 32'h2000_0000;
			geo_in[b].q = ts[31:30];
			rr = t - {ts[31:30], 30'b0};
			z_in[b] = {rr[31], rr};
		end
	end

	// CORDIC pipeline; index 0 is the input register
	logic                  vld_c [0:NS];
	geo_t                  geo_c [0:NS][2];
	logic signed [XW-1:0]  x_c   [0:NS][2];
	logic signed [XW-1:0]  y_c   [0:NS][2];
	logic signed [ZW-1:0]  z_c   [0:NS][2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c[0] <= 1'b0;
		end else if (en) begin
			vld_c[0] <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int b = 0; b < 2; b++) begin
				geo_c[0][b] <= geo_in[b];
				x_c[0][b]   <= obbsat_pkg::CORDIC_X0;
				y_c[0][b]   <= '0;
				z_c[0][b]   <= z_in[b];
			end
		end
	end

	for (genvar gi = 0; gi < NS; gi++) begin : g_cordic
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_c[gi+1] <= 1'b0;
			end else if (en) begin
				vld_c[gi+1] <= vld_c[gi];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int b = 0; b < 2; b++) begin
					geo_c[gi+1][b] <= geo_c[gi][b];
					if (!z_c[gi][b][ZW-1]) begin
						x_c[gi+1][b] <= x_c[gi][b] - (y_c[gi][b] >>> gi);
						y_c[gi+1][b] <= y_c[gi][b] + (x_c[gi][b] >>> gi);
						z_c[gi+1][b] <= z_c[gi][b] - obbsat_pkg::ATAN_TURN[gi];
					end else begin
						x_c[gi+1][b] <= x_c[gi][b] + (y_c[gi][b] >>> gi);
						y_c[gi+1][b] <= y_c[gi][b] - (x_c[gi][b] >>> gi);
						z_c[gi+1][b] <= z_c[gi][b] + obbsat_pkg::ATAN_TURN[gi];
					end
				end
			end
		end
	end

	// stage 2: round, clamp, quadrant
	localparam logic signed [XW-1:0] ONE_X  = XW'(1) <<< UFB;
	localparam logic signed [XW-1:0] HALF_C = XW'(1) <<< (29-UFB);

	logic                 vld_s2;
	geo_t                 geo_s2 [2];
	logic signed [UW-1:0] c_s2   [2];
	logic signed [UW-1:0] s_s2   [2];

	logic signed [UW-1:0] c_n [2];
	logic signed [UW-1:0] s_n [2];

	always_comb begin
		logic signed [XW-1:0] cc;
		logic signed [XW-1:0] ss;
		logic signed [UW-1:0] cn;
		logic signed [UW-1:0] sn;
		for (int b = 0; b < 2; b++) begin
			cc = (x_c[NS][b] + HALF_C) >>> (30-UFB);
			ss = (y_c[NS][b] + HALF_C) >>> (30-UFB);
			if (cc > ONE_X) cc = ONE_X;
			if (cc < -ONE_X) cc = -ONE_X;
			if (ss > ONE_X) ss = ONE_X;
			if (ss < -ONE_X) ss = -ONE_X;
			cn = cc[UW-1:0];
			sn = ss[UW-1:0];
			case (geo_c[NS][b].q)
				2'd0: begin c_n[b] = cn;  s_n[b] = sn;  end
				2'd1: begin c_n[b] = -sn; s_n[b] = cn;  end
				2'd2: begin c_n[b] = -cn; s_n[b] = -sn; end
				default: begin c_n[b] = sn; s_n[b] = -cn; end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_c[NS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int b = 0; b < 2; b++) begin
				geo_s2[b] <= geo_c[NS][b];
				c_s2[b]   <= c_n[b];
				s_s2[b]   <= s_n[b];
			end
		end
	end

	// stage 3: half-size products
	logic                  vld_s3;
	geo_t                  geo_s3  [2];
	logic signed [UW-1:0]  c_s3    [2];
	logic signed [UW-1:0]  s_s3    [2];
	logic signed [PRW-1:0] chw_s3  [2];
	logic signed [PRW-1:0] shh_s3  [2];
	logic signed [PRW-1:0] shw_s3  [2];
	logic signed [PRW-1:0] chh_s3  [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int b = 0; b < 2; b++) begin
				geo_s3[b] <= geo_s2[b];
				c_s3[b]   <= c_s2[b];
				s_s3[b]   <= s_s2[b];
				chw_s3[b] <= PRW'(c_s2[b]) * PRW'($signed({1'b0, geo_s2[b].hw}));
				shh_s3[b] <= PRW'(s_s2[b]) * PRW'($signed({1'b0, geo_s2[b].hh}));
				shw_s3[b] <= PRW'(s_s2[b]) * PRW'($signed({1'b0, geo_s2[b].hw}));
				chh_s3[b] <= PRW'(c_s2[b]) * PRW'($signed({1'b0, geo_s2[b].hh}));
			end
		end
	end

	// stage 4: corners
	localparam logic signed [PRW:0] HALF_U = (PRW+1)'(1) <<< (UFB-1);

	logic                 vld_s4;
	logic signed [UW-1:0] c_s4  [2];
	logic signed [UW-1:0] s_s4  [2];
	logic signed [VW-1:0] vx_s4 [2][4];
	logic signed [VW-1:0] vy_s4 [2][4];
	logic signed [DCW-1:0] dcx_s4;
	logic signed [DCW-1:0] dcy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		logic signed [PRW:0] ox;
		logic signed [PRW:0] oy;
		logic signed [PRW:0] a1;
		logic signed [PRW:0] a2;
		logic signed [PRW:0] a3;
		logic signed [PRW:0] a4;
		if (en) begin
			for (int b = 0; b < 2; b++) begin
				c_s4[b] <= c_s3[b];
				s_s4[b] <= s_s3[b];
				a1 = (PRW+1)'(chw_s3[b]);
				a2 = (PRW+1)'(shh_s3[b]);
				a3 = (PRW+1)'(shw_s3[b]);
				a4 = (PRW+1)'(chh_s3[b]);
				for (int k = 0; k < 4; k++) begin
					ox = ((k == 0 || k == 3) ? a1 : -a1) - ((k < 2) ? a2 : -a2);
					oy = ((k == 0 || k == 3) ? a3 : -a3) + ((k < 2) ? a4 : -a4);
					vx_s4[b][k] <= VW'(geo_s3[b].cx) + VW'((ox + HALF_U) >>> UFB);
					vy_s4[b][k] <= VW'(geo_s3[b].cy) + VW'((oy + HALF_U) >>> UFB);
				end
			end
			dcx_s4 <= DCW'(geo_s3[1].cx) - DCW'(geo_s3[0].cx);
			dcy_s4 <= DCW'(geo_s3[1].cy) - DCW'(geo_s3[0].cy);
		end
	end

	// axis j of box ab: j=0 is (s,-c), j=1 is (c,s); the negated axes give the same overlap
	logic signed [UW-1:0] ux_n [2][2];
	logic signed [UW-1:0] uy_n [2][2];

	always_comb begin
		for (int ab = 0; ab < 2; ab++) begin
			ux_n[ab][0] = s_s4[ab];
			uy_n[ab][0] = -c_s4[ab];
			ux_n[ab][1] = c_s4[ab];
			uy_n[ab][1] = s_s4[ab];
		end
	end

	// stage 5: projections
	logic                  vld_s5;
	logic signed [UW-1:0]  ux_s5 [2][2];
	logic signed [UW-1:0]  uy_s5 [2][2];
	logic signed [PW-1:0]  p_s5  [2][2][2][4];
	logic signed [DCW-1:0] dcx_s5;
	logic signed [DCW-1:0] dcy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dcx_s5 <= dcx_s4;
			dcy_s5 <= dcy_s4;
			for (int ab = 0; ab < 2; ab++) begin
				for (int j = 0; j < 2; j++) begin
					ux_s5[ab][j] <= ux_n[ab][j];
					uy_s5[ab][j] <= uy_n[ab][j];
					for (int vb = 0; vb < 2; vb++) begin
						for (int k = 0; k < 4; k++) begin
							p_s5[ab][j][vb][k] <= PW'(ux_n[ab][j]) * PW'(vx_s4[vb][k])
								+ PW'(uy_n[ab][j]) * PW'(vy_s4[vb][k]);
						end
					end
				end
			end
		end
	end

	// stage 6: extents
	logic                  vld_s6;
	logic signed [UW-1:0]  ux_s6 [2][2];
	logic signed [UW-1:0]  uy_s6 [2][2];
	logic signed [PW-1:0]  mn_s6 [2][2][2];
	logic signed [PW-1:0]  mx_s6 [2][2][2];
	logic signed [DCW-1:0] dcx_s6;
	logic signed [DCW-1:0] dcy_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (en) vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		logic signed [PW-1:0] mn;
		logic signed [PW-1:0] mx;
		if (en) begin
			dcx_s6 <= dcx_s5;
			dcy_s6 <= dcy_s5;
			ux_s6  <= ux_s5;
			uy_s6  <= uy_s5;
			for (int ab = 0; ab < 2; ab++) begin
				for (int j = 0; j < 2; j++) begin
					for (int vb = 0; vb < 2; vb++) begin
						mn = p_s5[ab][j][vb][0];
						mx = p_s5[ab][j][vb][0];
						for (int k = 1; k < 4; k++) begin
							if (p_s5[ab][j][vb][k] < mn) mn = p_s5[ab][j][vb][k];
							if (p_s5[ab][j][vb][k] > mx) mx = p_s5[ab][j][vb][k];
						end
						mn_s6[ab][j][vb] <= mn;
						mx_s6[ab][j][vb] <= mx;
					end
				end
			end
		end
	end

	// stage 7: separation and overlap per axis
	logic                  vld_s7;
	logic signed [UW-1:0]  ux_s7  [2][2];
	logic signed [UW-1:0]  uy_s7  [2][2];
	logic                  sep_s7 [2][2];
	logic signed [LW-1:0]  ol_s7  [2][2];
	logic signed [DCW-1:0] dcx_s7;
	logic signed [DCW-1:0] dcy_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else if (en) vld_s7 <= vld_s6;
	end

	always_ff @(posedge clk) begin
		logic signed [PW-1:0] hi;
		logic signed [PW-1:0] lo;
		if (en) begin
			dcx_s7 <= dcx_s6;
			dcy_s7 <= dcy_s6;
			ux_s7  <= ux_s6;
			uy_s7  <= uy_s6;
			for (int ab = 0; ab < 2; ab++) begin
				for (int j = 0; j < 2; j++) begin
					sep_s7[ab][j] <= (mn_s6[ab][j][0] > mx_s6[ab][j][1])
						|| (mn_s6[ab][j][1] > mx_s6[ab][j][0]);
					hi = (mx_s6[ab][j][0] < mx_s6[ab][j][1]) ? mx_s6[ab][j][0]
						: mx_s6[ab][j][1];
					lo = (mn_s6[ab][j][0] > mn_s6[ab][j][1]) ? mn_s6[ab][j][0]
						: mn_s6[ab][j][1];
					ol_s7[ab][j] <= LW'(hi) - LW'(lo);
				end
			end
		end
	end

	// stage 8: least overlap, earliest axis on ties
	logic                  vld_s8;
	logic                  hit_s8;
	logic signed [LW-1:0]  best_s8;
	logic signed [UW-1:0]  bx_s8;
	logic signed [UW-1:0]  by_s8;
	logic signed [DCW-1:0] dcx_s8;
	logic signed [DCW-1:0] dcy_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else if (en) vld_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		logic signed [LW-1:0] best;
		logic signed [UW-1:0] bx;
		logic signed [UW-1:0] by;
		if (en) begin
			best = ol_s7[0][0];
			bx   = ux_s7[0][0];
			by   = uy_s7[0][0];
			for (int n = 1; n < 4; n++) begin
				if (ol_s7[n/2][n%2] < best) begin
					best = ol_s7[n/2][n%2];
					bx   = ux_s7[n/2][n%2];
					by   = uy_s7[n/2][n%2];
				end
			end
			hit_s8  <= !(sep_s7[0][0] || sep_s7[0][1] || sep_s7[1][0] || sep_s7[1][1]);
			best_s8 <= best;
			bx_s8   <= bx;
			by_s8   <= by;
			dcx_s8  <= dcx_s7;
			dcy_s8  <= dcy_s7;
		end
	end

	// stage 9: direction test and depth rounding
	localparam logic signed [LW:0] HALF_D = (LW+1)'(1) <<< (UFB-1);

	logic                 vld_s9;
	logic                 hit_s9;
	logic                 flip_s9;
	logic signed [UW-1:0] bx_s9;
	logic signed [UW-1:0] by_s9;
	logic [DW-1:0]        depth_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s9 <= 1'b0;
		else if (en) vld_s9 <= vld_s8;
	end

	always_ff @(posedge clk) begin
		logic signed [DTW-1:0] dot;
		logic signed [LW:0]    dr;
		if (en) begin
			dot = DTW'(dcx_s8) * DTW'(bx_s8) + DTW'(dcy_s8) * DTW'(by_s8);
			dr  = ((LW+1)'(best_s8) + HALF_D) >>> UFB;
			hit_s9  <= hit_s8;
			flip_s9 <= dot[DTW-1];
			bx_s9   <= bx_s8;
			by_s9   <= by_s8;
			if (dr[LW])
				depth_s9 <= '0;
			else if (dr > (LW+1)'(obbsat_pkg::DEPTH_MAX))
				depth_s9 <= obbsat_pkg::DEPTH_MAX;
			else
				depth_s9 <= DW'(dr);
		end
	end

	// output register
	logic                 col_o;
	logic signed [UW-1:0] mx_o;
	logic signed [UW-1:0] my_o;
	logic [DW-1:0]        dep_o;

	assign col_o = m_tdata[0];
	assign mx_o  = m_tdata[1 +: UW];
	assign my_o  = m_tdata[1+UW +: UW];
	assign dep_o = m_tdata[1+2*UW +: DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (en) out_vld_q <= vld_s9;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (hit_s9)
				m_tdata <= ODW'({depth_s9, flip_s9 ? -by_s9 : by_s9,
					flip_s9 ? -bx_s9 : bx_s9, 1'b1});
			else
				m_tdata <= '0;
		end
	end

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !col_o |-> mx_o == '0 && my_o == '0 && dep_o == '0)
		else $error("miss beat carries a nonzero vector");

	a_hit_axis: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && col_o |-> mx_o != '0 || my_o != '0)
		else $error("hit beat carries a zero axis");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s9 && en |=> m_tvalid)
		else $error("pipeline beat lost at output register");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s9) && $stable(vld_c[0]))
		else $error("pipeline moved during stall");

endmodule
